### design/cabwf_pkg.sv
// Package for the chunk allocator: sizes, status codes and defaults.
// Used by every file in the design folder; depends on nothing.
package cabwf_pkg;
  localparam int MAX_CHUNKS_DEF   = 64;
  localparam int HEADER_BYTES_DEF = 32;
  localparam int PAGE_BYTES_DEF   = 4096;
  localparam int OFF_W  = 20;
  localparam int SIZE_W = 21;
  localparam int ST_W   = 3;
  localparam logic [SIZE_W-1:0] REGION_CAP = 21'd1048576;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_NO_FIT   = 3'd1;
  localparam logic [ST_W-1:0] ST_UNKNOWN  = 3'd2;
  localparam logic [ST_W-1:0] ST_DBL_FREE = 3'd3;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd4;

  localparam logic ADDR_FIT_MODE = 1'b0;
  localparam logic ADDR_REGION   = 1'b1;
endpackage

### design/chunk_allocator_best_worst_fit.sv
// Chunk allocator top level: APB registers, table memories and sequencer.
// Depends on cabwf_pkg.
//
// Usage: an input request (in_operation, in_request_size, in_payload_offset)
// is taken when in_valid and in_ready are high. in_ready is high only while
// the sequencer is idle and no result waits. Exactly one result (out_status,
// out_granted_offset) follows each request and is held in an output register
// until out_ready takes it; a stalled receiver therefore holds off the next
// request. An allocate scans every chunk in use, one entry a cycle through
// a single compare unit, and on a split moves the later entries up one
// place. A free scans up to the matching entry, and each merge moves the
// later entries down one place. A free below the header size is answered
// in the cycle after it is taken; any other request is paced by the table
// memory's one read port. After reset, or a write of region_bytes, the
// table is one free chunk; no clearing pass is needed because only entries
// below the chunk count are read. fit_mode and region_bytes are at byte
// addresses 0 and 4.
module chunk_allocator_best_worst_fit #(
  parameter int MAX_CHUNKS   = cabwf_pkg::MAX_CHUNKS_DEF,
  parameter int HEADER_BYTES = cabwf_pkg::HEADER_BYTES_DEF,
  parameter int PAGE_BYTES   = cabwf_pkg::PAGE_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [2:0]                    cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_operation,
  input  logic [cabwf_pkg::SIZE_W-1:0]  in_request_size,
  input  logic [cabwf_pkg::OFF_W-1:0]   in_payload_offset,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cabwf_pkg::ST_W-1:0]    out_status,
  output logic [cabwf_pkg::OFF_W-1:0]   out_granted_offset
);
  localparam int IW = $clog2(MAX_CHUNKS);
  localparam int CW = $clog2(MAX_CHUNKS + 1);
  localparam int OW = cabwf_pkg::OFF_W;
  localparam int SW = cabwf_pkg::SIZE_W;
  localparam logic [SW:0] HDR = (SW+1)'(HEADER_BYTES);
  localparam logic [SW:0] PG  = (SW+1)'(PAGE_BYTES);
  localparam logic [CW-1:0] MAXC = CW'(MAX_CHUNKS);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN   = 4'd1;
  localparam logic [3:0] S_AEVAL  = 4'd2;
  localparam logic [3:0] S_SHUP   = 4'd3;
  localparam logic [3:0] S_SPLIT  = 4'd4;
  localparam logic [3:0] S_FEVAL  = 4'd5;
  localparam logic [3:0] S_FNXT   = 4'd6;
  localparam logic [3:0] S_FPRV   = 4'd7;
  localparam logic [3:0] S_SHDN   = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;
  localparam logic [3:0] S_SPLIT2 = 4'd10;

  // Entry memory: {start, length, free}.
  localparam int EW = 2*OW + 1;
  logic [EW-1:0] mem [MAX_CHUNKS];
  logic [EW-1:0] rd_q;
  logic [IW-1:0] rd_a;
  logic          we;
  logic [IW-1:0] wa;
  logic [EW-1:0] wd;

  logic          fit_mode_r;
  logic [SW-1:0] region_r;
  logic [3:0]    st_r;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] idx_r;     // scan position of the entry being read
  logic          op_r;
  logic [SW:0]   need_r;
  logic [SW-1:0] req_r;
  logic [OW-1:0] tgt_r;
  logic          found_r;
  logic [IW-1:0] pick_r;
  logic [OW-1:0] pick_len_r, pick_start_r;
  logic          rdv_r;     // a read was issued last cycle
  logic [CW-1:0] rdi_r;     // index of that read
  logic          busy_init_r;
  logic [OW-1:0] init_len_r;
  logic [CW-1:0] mv_r;      // move cursor
  logic [IW-1:0] k_r;
  logic          phase_r;
  logic [OW-1:0] acc_len_r;
  logic          nxt_chk_r;
  logic          ov_r;
  logic [2:0]    ost_r;
  logic [OW-1:0] ogr_r;

  wire [OW-1:0] q_start = rd_q[EW-1 -: OW];
  wire [OW-1:0] q_len   = rd_q[OW:1];
  wire          q_free  = rd_q[0];

  // Configuration port.
  wire cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  wire cfg_a  = cfg_paddr[2];
  assign cfg_pready = 1'b1;
  always_comb begin
    cfg_prdata = 32'd0;
    if (cfg_a == cabwf_pkg::ADDR_REGION) cfg_prdata = {11'd0, region_r};
    else cfg_prdata = {31'd0, fit_mode_r};
  end

  // Region rounding for a write.
  logic [SW:0] rnd, rclamp;
  always_comb begin
    logic [SW:0] v;
    logic [SW:0] rem;
    v   = {1'b0, cfg_pwdata[SW-1:0]};
    rem = v % PG;
    rnd = (rem != '0) ? (v - rem + PG) : v;
    rclamp = (rnd > {1'b0, cabwf_pkg::REGION_CAP}) ? {1'b0, cabwf_pkg::REGION_CAP} : rnd;
  end
  wire [OW-1:0] len0 = (rclamp > HDR) ? OW'(rclamp - HDR) : '0;

  assign in_ready  = (st_r == S_IDLE) && !ov_r && !busy_init_r;
  assign out_valid = ov_r;
  assign out_status = ost_r;
  assign out_granted_offset = ogr_r;
  wire take = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[rd_a];
  end

  logic [OW-1:0] sum_len;
  logic [OW-1:0] prv_len;
  assign sum_len = acc_len_r + q_len + OW'(HEADER_BYTES);
  assign prv_len = q_len + acc_len_r + OW'(HEADER_BYTES);
  wire better = fit_mode_r ? (q_len > pick_len_r) : (q_len < pick_len_r);
  wire fits   = q_free && ({2'b00, q_len} >= need_r);

  // Read address and the single write port of the entry memory.
  always_comb begin
    rd_a = idx_r[IW-1:0]; we = 1'b0; wa = '0; wd = '0;
    unique case (st_r)
      S_AEVAL: begin
        if (found_r && !({2'b00, pick_len_r} > need_r)) begin
          we = 1'b1; wa = pick_r; wd = {pick_start_r, pick_len_r, 1'b0};
        end
      end
      S_SHUP: begin
        rd_a = IW'(mv_r - 1'b1);
        if (!(mv_r <= CW'(pick_r) + 1'b1) && phase_r) begin
          we = 1'b1; wa = mv_r[IW-1:0]; wd = rd_q;
        end
      end
      S_SPLIT: begin
        we = 1'b1; wa = IW'(pick_r + 1'b1);
        wd = {pick_start_r + OW'(need_r), pick_len_r - OW'(need_r), 1'b1};
      end
      S_SPLIT2: begin
        we = 1'b1; wa = pick_r; wd = {pick_start_r, OW'(req_r), 1'b0};
      end
      S_FEVAL: begin
        we = 1'b1; wa = k_r; wd = {tgt_r, acc_len_r, 1'b1};
      end
      S_FNXT: begin
        rd_a = IW'(k_r + 1'b1);
        if (!(CW'(k_r) + 1'b1 >= cnt_r) && phase_r && q_free) begin
          we = 1'b1; wa = k_r; wd = {tgt_r, sum_len, 1'b1};
        end
      end
      S_FPRV: begin
        rd_a = IW'(k_r - 1'b1);
        if (k_r != '0 && phase_r && q_free) begin
          we = 1'b1; wa = IW'(k_r - 1'b1); wd = {q_start, prv_len, 1'b1};
        end
      end
      S_SHDN: begin
        rd_a = IW'(mv_r + 1'b1);
        if (!(mv_r >= cnt_r) && phase_r) begin
          we = 1'b1; wa = mv_r[IW-1:0]; wd = rd_q;
        end
      end
      default: rd_a = idx_r[IW-1:0];
    endcase
    if (busy_init_r) begin
      we = 1'b1; wa = '0; wd = {{OW{1'b0}}, init_len_r, 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_mode_r <= 1'b0; region_r <= cabwf_pkg::REGION_CAP;
      st_r <= S_IDLE; cnt_r <= CW'(1); ov_r <= 1'b0;
      busy_init_r <= 1'b1; init_len_r <= OW'({1'b0, cabwf_pkg::REGION_CAP} - HDR);
      rdv_r <= 1'b0;
    end else begin
      busy_init_r <= 1'b0;
      if (cfg_wr) begin
        if (cfg_a == cabwf_pkg::ADDR_REGION) begin
          region_r <= cfg_pwdata[SW-1:0];
          init_len_r <= len0; busy_init_r <= 1'b1; cnt_r <= CW'(1);
        end else fit_mode_r <= cfg_pwdata[0];
      end
      if (ov_r && out_ready) ov_r <= 1'b0;
      rdv_r <= 1'b0;
      unique case (st_r)
        S_IDLE: if (take) begin
          op_r <= in_operation; req_r <= in_request_size;
          need_r <= {1'b0, in_request_size} + HDR;
          tgt_r <= in_payload_offset - OW'(HEADER_BYTES);
          found_r <= 1'b0; idx_r <= '0;
          if (in_operation && ({2'b00, in_payload_offset} < HDR)) begin
            ost_r <= cabwf_pkg::ST_UNKNOWN; ogr_r <= '0; ov_r <= 1'b1;
          end else st_r <= S_SCAN;
        end
        S_SCAN: begin
          // one read a cycle; the previous read is judged by the compare unit
          if (rdv_r) begin
            if (!op_r) begin
              if (fits && (!found_r || better)) begin
                found_r <= 1'b1; pick_r <= rdi_r[IW-1:0];
                pick_len_r <= q_len; pick_start_r <= q_start;
              end
            end else if (q_start == tgt_r) begin
              found_r <= 1'b1; k_r <= rdi_r[IW-1:0]; acc_len_r <= q_len;
              st_r <= S_FEVAL;
              if (q_free) begin
                ost_r <= cabwf_pkg::ST_DBL_FREE; ogr_r <= '0; st_r <= S_DONE;
              end
            end
          end
          if (!(op_r && rdv_r && q_start == tgt_r)) begin
            if (idx_r < cnt_r) begin
              rdv_r <= 1'b1; rdi_r <= idx_r; idx_r <= idx_r + 1'b1;
            end else if (!rdv_r) st_r <= op_r ? S_DONE : S_AEVAL;
            if (op_r && !(idx_r < cnt_r) && !rdv_r) begin
              ost_r <= cabwf_pkg::ST_UNKNOWN; ogr_r <= '0;
            end
          end
        end
        S_AEVAL: begin
          ogr_r <= '0;
          if (!found_r) begin
            ost_r <= cabwf_pkg::ST_NO_FIT; st_r <= S_DONE;
          end else if ({2'b00, pick_len_r} > need_r) begin
            if (cnt_r >= MAXC) begin
              ost_r <= cabwf_pkg::ST_FULL; st_r <= S_DONE;
            end else begin
              mv_r <= cnt_r; phase_r <= 1'b0; st_r <= S_SHUP;
            end
          end else begin
            ost_r <= cabwf_pkg::ST_OK;
            ogr_r <= pick_start_r + OW'(HEADER_BYTES); st_r <= S_DONE;
          end
        end
        S_SHUP: begin
          // read mv-1 then write it to mv
          if (mv_r <= CW'(pick_r) + 1'b1) st_r <= S_SPLIT;
          else if (!phase_r) phase_r <= 1'b1;
          else begin
            mv_r <= mv_r - 1'b1; phase_r <= 1'b0;
          end
        end
        S_SPLIT: begin
          st_r <= S_SPLIT2;
        end
        S_SPLIT2: begin
          cnt_r <= cnt_r + 1'b1;
          ost_r <= cabwf_pkg::ST_OK;
          ogr_r <= pick_start_r + OW'(HEADER_BYTES); st_r <= S_DONE;
        end
        S_FEVAL: begin
          ost_r <= cabwf_pkg::ST_OK; ogr_r <= '0;
          phase_r <= 1'b0; nxt_chk_r <= 1'b1; st_r <= S_FNXT;
        end
        S_FNXT: begin
          if (CW'(k_r) + 1'b1 >= cnt_r) st_r <= S_FPRV;
          else if (!phase_r) phase_r <= 1'b1;
          else begin
            phase_r <= 1'b0;
            if (q_free) begin
              acc_len_r <= sum_len;
              mv_r <= CW'(k_r) + 1'b1; cnt_r <= cnt_r - 1'b1; st_r <= S_SHDN;
            end else st_r <= S_FPRV;
          end
          nxt_chk_r <= 1'b1;
        end
        S_FPRV: begin
          nxt_chk_r <= 1'b0;
          if (k_r == '0) st_r <= S_DONE;
          else if (!phase_r) phase_r <= 1'b1;
          else begin
            phase_r <= 1'b0;
            if (q_free) begin
              mv_r <= CW'(k_r); cnt_r <= cnt_r - 1'b1; st_r <= S_SHDN;
              k_r <= '0;
            end else st_r <= S_DONE;
          end
        end
        S_SHDN: begin
          // read mv+1, write to mv, until the end of the table
          if (mv_r >= cnt_r) begin
            phase_r <= 1'b0;
            st_r <= (k_r != '0 || nxt_chk_r) ? S_FPRV : S_DONE;
            nxt_chk_r <= 1'b0;
          end else if (!phase_r) phase_r <= 1'b1;
          else begin
            mv_r <= mv_r + 1'b1; phase_r <= 1'b0;
          end
        end
        S_DONE: begin
          ov_r <= 1'b1; st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) ov_r |-> st_r == S_IDLE)
    else $error("result pending while busy");
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r != '0 && cnt_r <= MAXC)
    else $error("chunk count out of range");
  assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && ost_r != cabwf_pkg::ST_OK) |-> ogr_r == '0)
    else $error("offset on failure");
endmodule

### test/testbench.sv
// Testbench for chunk_allocator_best_worst_fit: random and directed allocate and free requests,
// checked against a scoreboard that models the chunk table. Depends on cabwf_pkg and the design.
`timescale 1ns / 1ps

class alloc_scoreboard;
  localparam int unsigned HDR   = cabwf_pkg::HEADER_BYTES_DEF;
  localparam int unsigned PAGE  = cabwf_pkg::PAGE_BYTES_DEF;
  localparam int unsigned SLOTS = cabwf_pkg::MAX_CHUNKS_DEF;
  localparam int unsigned CAP   = 1048576;
  localparam int unsigned MASK  = 20'hFFFFF;

  bit          worst_fit;
  int unsigned region;
  int unsigned chunk_start [SLOTS];
  int unsigned chunk_len [SLOTS];
  bit          chunk_free [SLOTS];
  int unsigned chunk_count;
  logic [2:0]  want_status [$];
  logic [19:0] want_offset [$];
  int          mismatches;

  function new();
    worst_fit = 1'b0;
    region = CAP;
    mismatches = 0;
    clear_table();
  endfunction

  function void clear_table();
    int unsigned r;
    r = region;
    if (r % PAGE != 0) r = (r / PAGE) * PAGE + PAGE;
    if (r > CAP) r = CAP;
    chunk_count = 1;
    chunk_start[0] = 0;
    chunk_len[0] = (r > HDR) ? r - HDR : 0;
    chunk_free[0] = 1'b1;
  endfunction

  function void write_reg(bit is_region, int unsigned value);
    if (is_region) begin
      region = value & 21'h1FFFFF;
      clear_table();
    end else begin
      worst_fit = value[0];
    end
  endfunction

  // Folds entry k+1 into entry k and closes the gap it leaves.
  function void merge_next(int unsigned k);
    chunk_len[k] = (chunk_len[k] + chunk_len[k+1] + HDR) & MASK;
    for (int unsigned i = k + 1; i + 1 < chunk_count; i++) begin
      chunk_start[i] = chunk_start[i+1];
      chunk_len[i] = chunk_len[i+1];
      chunk_free[i] = chunk_free[i+1];
    end
    chunk_count--;
  endfunction

  function void note_request(bit op, int unsigned req, int unsigned off);
    logic [2:0] st;
    int unsigned granted, need, pick, k;
    bit found;
    granted = 0;
    found = 1'b0;
    pick = 0;
    if (op == 1'b0) begin
      need = req + HDR;
      for (int unsigned i = 0; i < chunk_count; i++) begin
        if (chunk_free[i] && chunk_len[i] >= need) begin
          if (!found) begin
            found = 1'b1;
            pick = i;
          end else if (worst_fit ? chunk_len[i] > chunk_len[pick]
                                 : chunk_len[i] < chunk_len[pick]) begin
            pick = i;
          end
        end
      end
      if (!found) st = cabwf_pkg::ST_NO_FIT;
      else if (chunk_len[pick] > need && chunk_count >= SLOTS) st = cabwf_pkg::ST_FULL;
      else begin
        st = cabwf_pkg::ST_OK;
        if (chunk_len[pick] > need) begin
          for (int unsigned i = chunk_count; i > pick + 1; i--) begin
            chunk_start[i] = chunk_start[i-1];
            chunk_len[i] = chunk_len[i-1];
            chunk_free[i] = chunk_free[i-1];
          end
          chunk_start[pick+1] = (chunk_start[pick] + need) & MASK;
          chunk_len[pick+1] = chunk_len[pick] - need;
          chunk_free[pick+1] = 1'b1;
          chunk_len[pick] = req & MASK;
          chunk_count++;
        end
        chunk_free[pick] = 1'b0;
        granted = (chunk_start[pick] + HDR) & MASK;
      end
    end else begin
      st = cabwf_pkg::ST_UNKNOWN;
      if (off >= HDR) begin
        for (int unsigned i = 0; i < chunk_count; i++) begin
          if (!found && chunk_start[i] == off - HDR) begin
            found = 1'b1;
            k = i;
          end
        end
      end
      if (found && chunk_free[k]) st = cabwf_pkg::ST_DBL_FREE;
      else if (found) begin
        st = cabwf_pkg::ST_OK;
        chunk_free[k] = 1'b1;
        if (k + 1 < chunk_count && chunk_free[k+1]) merge_next(k);
        if (k > 0 && chunk_free[k-1]) merge_next(k - 1);
      end
    end
    want_status.push_back(st);
    want_offset.push_back(granted[19:0]);
  endfunction

  function void check_result(logic [2:0] st, logic [19:0] off);
    logic [2:0] es;
    logic [19:0] eo;
    if (want_status.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result: status %0d offset %0h", st, off);
      return;
    end
    es = want_status.pop_front();
    eo = want_offset.pop_front();
    if (st !== es || off !== eo) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: status exp %0d got %0d, offset exp %0h got %0h", es, st, eo, off);
    end
  endfunction
endclass

module testbench;
  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [2:0]                   cfg_paddr = '0;
  logic [31:0]                  cfg_pwdata = '0;
  logic [31:0]                  cfg_prdata;
  logic                         cfg_pready;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic                         in_operation = 1'b0;
  logic [cabwf_pkg::SIZE_W-1:0] in_request_size = '0;
  logic [cabwf_pkg::OFF_W-1:0]  in_payload_offset = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [cabwf_pkg::ST_W-1:0]   out_status;
  logic [cabwf_pkg::OFF_W-1:0]  out_granted_offset;

  alloc_scoreboard table_model = new();
  bit              steady;

  chunk_allocator_best_worst_fit dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) table_model.check_result(out_status, out_granted_offset);
    out_ready <= steady || $urandom_range(99) >= 8;
  end

  task automatic issue(bit op, int unsigned req, int unsigned off);
    if (!steady && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_request_size <= req[cabwf_pkg::SIZE_W-1:0];
    in_payload_offset <= off[cabwf_pkg::OFF_W-1:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    table_model.note_request(op, req & 21'h1FFFFF, off & 20'hFFFFF);
  endtask

  // Registers are only touched once the block has gone quiet.
  task automatic write_reg(logic idx, int unsigned value);
    in_valid <= 1'b0;
    while (table_model.want_status.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    table_model.write_reg(idx == cabwf_pkg::ADDR_REGION, value);
  endtask

  task automatic random_requests(int n);
    int unsigned k, pick, sz;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      k = $urandom_range(table_model.chunk_count - 1);
      if (pick < 55) begin
        pick = $urandom_range(99);
        if (pick < 60) sz = $urandom_range(4095);
        else if (pick < 78) sz = $urandom_range(65536);
        else if (pick < 88) sz = $urandom;
        else if (table_model.chunk_len[k] < 32) sz = 0;
        else sz = table_model.chunk_len[k] - 32 + $urandom_range(1);
        issue(1'b0, sz, $urandom);
      end else if (pick < 90) begin
        issue(1'b1, $urandom, table_model.chunk_start[k] + 32);
      end else if (pick < 95) begin
        issue(1'b1, $urandom, $urandom_range(31));
      end else begin
        issue(1'b1, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    steady = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: exact fit, oversized, double free, low and unknown addresses, both fits.
    issue(1'b0, 0, 0);
    issue(1'b0, 1048576, 0);
    issue(1'b0, 21'h1FFFFF, 0);
    issue(1'b0, 100, 0);
    issue(1'b0, 4000, 0);
    issue(1'b0, 100, 0);
    issue(1'b1, 0, 32 + 32);
    issue(1'b1, 0, 32 + 32);
    issue(1'b1, 0, 31);
    issue(1'b1, 0, 0);
    issue(1'b1, 0, 20'hFFFFF);
    issue(1'b0, 50, 0);
    issue(1'b0, 0, 0);
    write_reg(cabwf_pkg::ADDR_FIT_MODE, 1);
    issue(1'b0, 10, 0);
    issue(1'b1, 0, 32);
    write_reg(cabwf_pkg::ADDR_REGION, 8192);
    issue(1'b0, 8192 - 64, 0);
    issue(1'b0, 8192 - 64 - 32, 0);
    issue(1'b1, 0, 32);
    write_reg(cabwf_pkg::ADDR_REGION, 0);
    issue(1'b0, 0, 0);
    // Small requests until the table runs out of entries.
    write_reg(cabwf_pkg::ADDR_REGION, 1048576);
    for (int i = 0; i < 66; i++) issue(1'b0, $urandom_range(64), 0);
    write_reg(cabwf_pkg::ADDR_FIT_MODE, 0);
    random_requests(300);
    steady = 1'b1;
    random_requests(150);
    steady = 1'b0;
    write_reg(cabwf_pkg::ADDR_REGION, 5000);
    write_reg(cabwf_pkg::ADDR_FIT_MODE, 1);
    random_requests(300);
    write_reg(cabwf_pkg::ADDR_REGION, 1);
    random_requests(150);
    write_reg(cabwf_pkg::ADDR_REGION, 31);
    random_requests(40);
    write_reg(cabwf_pkg::ADDR_REGION, 21'h1FFFFF);
    write_reg(cabwf_pkg::ADDR_FIT_MODE, 0);
    random_requests(350);
    write_reg(cabwf_pkg::ADDR_REGION, 1048575);
    write_reg(cabwf_pkg::ADDR_FIT_MODE, 1);
    random_requests(575);
    in_valid <= 1'b0;
    while (table_model.want_status.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
    if (table_model.mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
